/* hw/rtl/xyzok_pkg.sv */
// Shared types, widths and fixed-point matrix constants for the XYZ to Oklab pipeline.
// No dependencies; imported by every module of the block.
package xyzok_pkg;

    localparam int InW       = 16;
    localparam int OutW      = 16;
    localparam int CoefW     = 27;
    localparam int MagW      = 42;
    localparam int DivStages = 6;
    localparam int DivBits   = 7;
    localparam int RemW      = 5;
    localparam int FracW     = 14;
    localparam int NW        = 52;
    localparam int RootW     = 18;
    localparam int TW        = 56;
    localparam int CbrtBits  = 18;
    localparam int LabShift  = 26;
    localparam int LmsStages = 3;
    localparam int LabStages = 4;
    localparam int Latency   = LmsStages + DivStages + CbrtBits + 1 + LabStages;

    localparam logic [RemW:0] Divisor = 6'd25;

    localparam longint Scale = 64'sd16777216;
    localparam longint Half  = 64'sd5000000000;
    localparam longint Den   = 64'sd10000000000;

    localparam logic signed [CoefW-1:0] LmsCoef [9] = '{
        CoefW'((64'sd8189330101 * Scale + Half) / Den),
        CoefW'((64'sd3618667424 * Scale + Half) / Den),
        CoefW'(-((64'sd1288597137 * Scale + Half) / Den)),
        CoefW'((64'sd329845436 * Scale + Half) / Den),
        CoefW'((64'sd9293118715 * Scale + Half) / Den),
        CoefW'((64'sd361456387 * Scale + Half) / Den),
        CoefW'((64'sd482003018 * Scale + Half) / Den),
        CoefW'((64'sd2643662691 * Scale + Half) / Den),
        CoefW'((64'sd6338517070 * Scale + Half) / Den)
    };

    localparam logic signed [CoefW-1:0] LabCoef [9] = '{
        CoefW'((64'sd2104542553 * Scale + Half) / Den),
        CoefW'((64'sd7936177850 * Scale + Half) / Den),
        CoefW'(-((64'sd40720468 * Scale + Half) / Den)),
        CoefW'((64'sd19779984951 * Scale + Half) / Den),
        CoefW'(-((64'sd24285922050 * Scale + Half) / Den)),
        CoefW'((64'sd4505937099 * Scale + Half) / Den),
        CoefW'((64'sd259040371 * Scale + Half) / Den),
        CoefW'((64'sd7827717662 * Scale + Half) / Den),
        CoefW'(-((64'sd8086757660 * Scale + Half) / Den))
    };

    typedef struct packed {
        logic valid;
        logic line_end;
    } t_side;

    // floor((r * 16384 + 12) / 25) for a remainder of the divide by 25
    function automatic logic [FracW-1:0] rem_frac(input logic [RemW-1:0] r);
        logic [FracW-1:0] f;
        unique case (r)
            5'd0:    f = 14'd0;
            5'd1:    f = 14'd655;
            5'd2:    f = 14'd1311;
            5'd3:    f = 14'd1966;
            5'd4:    f = 14'd2621;
            5'd5:    f = 14'd3277;
            5'd6:    f = 14'd3932;
            5'd7:    f = 14'd4588;
            5'd8:    f = 14'd5243;
            5'd9:    f = 14'd5898;
            5'd10:   f = 14'd6554;
            5'd11:   f = 14'd7209;
            5'd12:   f = 14'd7864;
            5'd13:   f = 14'd8520;
            5'd14:   f = 14'd9175;
            5'd15:   f = 14'd9830;
            5'd16:   f = 14'd10486;
            5'd17:   f = 14'd11141;
            5'd18:   f = 14'd11796;
            5'd19:   f = 14'd12452;
            5'd20:   f = 14'd13107;
            5'd21:   f = 14'd13763;
            5'd22:   f = 14'd14418;
            5'd23:   f = 14'd15073;
            5'd24:   f = 14'd15729;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

/* hw/rtl/xyzok_lms.sv */
// XYZ to LMS matrix stage: products, row sums, then sign and magnitude.
// Depends on xyzok_pkg.
module xyzok_lms import xyzok_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_side                  i_side,
    input  logic signed [InW-1:0]  i_xyz [3],
    output t_side                  o_side,
    output logic [MagW-1:0]        o_mag [3],
    output logic                   o_neg [3]
);
    localparam int ProdW = CoefW + InW;
    localparam int AccW  = ProdW + 2;

    logic signed [ProdW-1:0] r_prod [3][3];
    logic signed [AccW-1:0]  r_acc [3];
    logic [MagW-1:0]         r_mag [3];
    logic                    r_neg [3];
    t_side                   r_side [LmsStages];
    logic [AccW-1:0]         n_abs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_acc[i][AccW-1] ? AccW'(-r_acc[i]) : AccW'(r_acc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LmsStages; s++) begin
                r_side[s] <= '0;
            end
        end else begin
            r_side[0] <= i_side;
            for (int s = 1; s < LmsStages; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= ProdW'(LmsCoef[3*i+j]) * ProdW'(i_xyz[j]);
            end
            r_acc[i] <= AccW'(r_prod[i][0]) + AccW'(r_prod[i][1]) + AccW'(r_prod[i][2]);
            r_neg[i] <= r_acc[i][AccW-1];
            r_mag[i] <= n_abs[i][MagW-1:0];
        end
    end

    assign o_side = r_side[LmsStages-1];
    assign o_mag  = r_mag;
    assign o_neg  = r_neg;

endmodule

/* hw/rtl/xyzok_div25.sv */
// Pipelined restoring divide of the LMS magnitudes by 25, several bits a stage,
// then Q38.14 assembly of quotient and remainder fraction. Depends on xyzok_pkg.
module xyzok_div25 import xyzok_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_side           i_side,
    input  logic [MagW-1:0] i_mag [3],
    input  logic            i_neg [3],
    output t_side           o_side,
    output logic [NW-1:0]   o_n [3],
    output logic            o_neg [3]
);
    t_side           r_side [DivStages];
    logic            r_neg  [DivStages][3];
    logic [MagW-1:0] r_mag  [DivStages][3];
    logic [MagW-1:0] r_quo  [DivStages][3];
    logic [RemW-1:0] r_rem  [DivStages][3];

    genvar s;
    for (s = 0; s < DivStages; s++) begin : g_stage
        t_side           in_side;
        logic            in_neg [3];
        logic [MagW-1:0] in_mag [3];
        logic [MagW-1:0] in_quo [3];
        logic [RemW-1:0] in_rem [3];
        logic [MagW-1:0] n_quo  [3];
        logic [RemW-1:0] n_rem  [3];

        if (s == 0) begin : g_first
            assign in_side = i_side;
            assign in_neg  = i_neg;
            assign in_mag  = i_mag;
            assign in_quo  = '{default: '0};
            assign in_rem  = '{default: '0};
        end else begin : g_next
            assign in_side = r_side[s-1];
            assign in_neg  = r_neg[s-1];
            assign in_mag  = r_mag[s-1];
            assign in_quo  = r_quo[s-1];
            assign in_rem  = r_rem[s-1];
        end

        always_comb begin
            logic [RemW:0] t;
            for (int i = 0; i < 3; i++) begin
                n_quo[i] = in_quo[i];
                n_rem[i] = in_rem[i];
                for (int k = 0; k < DivBits; k++) begin
                    t = {n_rem[i], in_mag[i][MagW-1-s*DivBits-k]};
                    if (t >= Divisor) begin
                        n_rem[i] = RemW'(t - Divisor);
                        n_quo[i][MagW-1-s*DivBits-k] = 1'b1;
                    end else begin
                        n_rem[i] = t[RemW-1:0];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else begin
                r_side[s] <= in_side;
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[s] <= in_neg;
            r_mag[s] <= in_mag;
            r_quo[s] <= n_quo;
            r_rem[s] <= n_rem;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_n[i] = {r_quo[DivStages-1][i][NW-FracW-1:0], rem_frac(r_rem[DivStages-1][i])};
        end
    end

    assign o_side = r_side[DivStages-1];
    assign o_neg  = r_neg[DivStages-1];

endmodule

/* hw/rtl/xyzok_cbrt.sv */
// Cube root by digit recurrence, one root bit a stage, then round to nearest
// and restore the sign. Depends on xyzok_pkg.
module xyzok_cbrt import xyzok_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_side                  i_side,
    input  logic [NW-1:0]          i_n [3],
    input  logic                   i_neg [3],
    output t_side                  o_side,
    output logic signed [RootW:0]  o_root [3]
);
    t_side             r_side [CbrtBits];
    logic              r_neg  [CbrtBits][3];
    logic [TW-1:0]     r_rem  [CbrtBits][3];
    logic [TW-1:0]     r_sq   [CbrtBits][3];
    logic [RootW-1:0]  r_root [CbrtBits][3];
    t_side             r_side_out;
    logic signed [RootW:0] r_out [3];

    genvar s;
    for (s = 0; s < CbrtBits; s++) begin : g_digit
        localparam int B = CbrtBits - 1 - s;
        t_side            in_side;
        logic             in_neg  [3];
        logic [TW-1:0]    in_rem  [3];
        logic [TW-1:0]    in_sq   [3];
        logic [RootW-1:0] in_root [3];
        logic [TW-1:0]    n_rem   [3];
        logic [TW-1:0]    n_sq    [3];
        logic [RootW-1:0] n_root  [3];

        if (s == 0) begin : g_first
            assign in_side = i_side;
            assign in_neg  = i_neg;
            assign in_sq   = '{default: '0};
            assign in_root = '{default: '0};
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign in_rem[i] = TW'(i_n[i]);
            end
        end else begin : g_next
            assign in_side = r_side[s-1];
            assign in_neg  = r_neg[s-1];
            assign in_rem  = r_rem[s-1];
            assign in_sq   = r_sq[s-1];
            assign in_root = r_root[s-1];
        end

        always_comb begin
            logic [TW-1:0] sq3;
            logic [TW-1:0] r3;
            logic [TW-1:0] t;
            for (int i = 0; i < 3; i++) begin
                sq3 = in_sq[i] + (in_sq[i] << 1);
                r3  = TW'(in_root[i]) + (TW'(in_root[i]) << 1);
                t   = (sq3 << B) + (r3 << (2 * B)) + (TW'(1) << (3 * B));
                if (t <= in_rem[i]) begin
                    n_rem[i]  = in_rem[i] - t;
                    n_sq[i]   = in_sq[i] + (TW'(in_root[i]) << (B + 1)) + (TW'(1) << (2 * B));
                    n_root[i] = in_root[i] | (RootW'(1) << B);
                end else begin
                    n_rem[i]  = in_rem[i];
                    n_sq[i]   = in_sq[i];
                    n_root[i] = in_root[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else begin
                r_side[s] <= in_side;
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[s]  <= in_neg;
            r_rem[s]  <= n_rem;
            r_sq[s]   <= n_sq;
            r_root[s] <= n_root;
        end
    end

    logic signed [RootW:0] n_out [3];

    // round up when (2r+1)^3 <= 8n, i.e. 12r^2 + 6r + 1 <= 8(n - r^3)
    always_comb begin
        logic [TW-1:0]    sq;
        logic [TW-1:0]    rt;
        logic [TW-1:0]    lhs;
        logic [RootW-1:0] r;
        for (int i = 0; i < 3; i++) begin
            sq  = r_sq[CbrtBits-1][i];
            rt  = TW'(r_root[CbrtBits-1][i]);
            lhs = (sq << 3) + (sq << 2) + (rt << 2) + (rt << 1) + TW'(1);
            r   = r_root[CbrtBits-1][i];
            if (lhs <= (r_rem[CbrtBits-1][i] << 3)) begin
                r = r + RootW'(1);
            end
            n_out[i] = r_neg[CbrtBits-1][i] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_out <= '0;
        end else begin
            r_side_out <= r_side[CbrtBits-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_side = r_side_out;
    assign o_root = r_out;

endmodule

/* hw/rtl/xyzok_lab.sv */
// LMS root to Oklab matrix stage: products, row sums, rounding shift, saturation.
// Depends on xyzok_pkg.
module xyzok_lab import xyzok_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_side                  i_side,
    input  logic signed [RootW:0]  i_root [3],
    output t_side                  o_side,
    output logic signed [OutW-1:0] o_lab [3]
);
    localparam int ProdW = CoefW + RootW + 1;
    localparam int AccW  = ProdW + 2;
    localparam int RndW  = AccW - LabShift;

    logic signed [ProdW-1:0] r_prod [3][3];
    logic signed [AccW-1:0]  r_acc [3];
    logic [RndW-1:0]         r_mag [3];
    logic                    r_neg [3];
    logic signed [OutW-1:0]  r_lab [3];
    t_side                   r_side [LabStages];
    logic [AccW-1:0]         n_rnd [3];
    logic signed [OutW-1:0]  n_lab [3];

    always_comb begin
        logic [AccW-1:0] abs_v;
        for (int i = 0; i < 3; i++) begin
            abs_v    = r_acc[i][AccW-1] ? AccW'(-r_acc[i]) : AccW'(r_acc[i]);
            n_rnd[i] = abs_v + (AccW'(1) << (LabShift - 1));
        end
    end

    // clamp the magnitude, then apply the sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_neg[i]) begin
                if (r_mag[i] > RndW'(1 << (OutW - 1))) begin
                    n_lab[i] = OutW'(-(1 << (OutW - 1)));
                end else begin
                    n_lab[i] = OutW'(-$signed({1'b0, r_mag[i]}));
                end
            end else begin
                if (r_mag[i] > RndW'((1 << (OutW - 1)) - 1)) begin
                    n_lab[i] = OutW'((1 << (OutW - 1)) - 1);
                end else begin
                    n_lab[i] = OutW'(r_mag[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LabStages; s++) begin
                r_side[s] <= '0;
            end
        end else begin
            r_side[0] <= i_side;
            for (int s = 1; s < LabStages; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= ProdW'(LabCoef[3*i+j]) * ProdW'(i_root[j]);
            end
            r_acc[i] <= AccW'(r_prod[i][0]) + AccW'(r_prod[i][1]) + AccW'(r_prod[i][2]);
            r_neg[i] <= r_acc[i][AccW-1];
            r_mag[i] <= n_rnd[i][AccW-1:LabShift];
            r_lab[i] <= n_lab[i];
        end
    end

    assign o_side = r_side[LabStages-1];
    assign o_lab  = r_lab;

endmodule

/* hw/rtl/xyz_to_oklab_converter_unit.sv */
// CIE XYZ (D65) to Oklab pixel converter, top level.
// Pipeline stages from start to o_valid: 3 LMS matrix, 6 divide, 19 cube root, 4 Oklab.
// Throughput: one pixel per cycle; busy never rises, the pipeline has no stalls.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; in-flight pixels drop.
// Depends on xyzok_pkg, xyzok_lms, xyzok_div25, xyzok_cbrt, xyzok_lab.
module xyz_to_oklab_converter_unit import xyzok_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic signed [InW-1:0]  i_x_value,
    input  logic signed [InW-1:0]  i_y_value,
    input  logic signed [InW-1:0]  i_z_value,
    input  logic                   i_line_end,
    output logic                   o_valid,
    output logic signed [OutW-1:0] o_ok_lightness,
    output logic signed [OutW-1:0] o_ok_a,
    output logic signed [OutW-1:0] o_ok_b,
    output logic                   o_line_end_out
);
    t_side                  in_side;
    t_side                  lms_side;
    t_side                  div_side;
    t_side                  cbrt_side;
    t_side                  lab_side;
    logic signed [InW-1:0]  xyz [3];
    logic [MagW-1:0]        lms_mag [3];
    logic                   lms_neg [3];
    logic [NW-1:0]          div_n [3];
    logic                   div_neg [3];
    logic signed [RootW:0]  root [3];
    logic signed [OutW-1:0] lab [3];

    assign o_busy           = 1'b0;
    assign in_side.valid    = i_start & ~o_busy;
    assign in_side.line_end = i_line_end;
    assign xyz[0]           = i_x_value;
    assign xyz[1]           = i_y_value;
    assign xyz[2]           = i_z_value;

    xyzok_lms u_lms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (in_side),
        .i_xyz   (xyz),
        .o_side  (lms_side),
        .o_mag   (lms_mag),
        .o_neg   (lms_neg)
    );

    xyzok_div25 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (lms_side),
        .i_mag   (lms_mag),
        .i_neg   (lms_neg),
        .o_side  (div_side),
        .o_n     (div_n),
        .o_neg   (div_neg)
    );

    xyzok_cbrt u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (div_side),
        .i_n     (div_n),
        .i_neg   (div_neg),
        .o_side  (cbrt_side),
        .o_root  (root)
    );

    xyzok_lab u_lab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (cbrt_side),
        .i_root  (root),
        .o_side  (lab_side),
        .o_lab   (lab)
    );

    assign o_valid        = lab_side.valid;
    assign o_line_end_out = lab_side.line_end;
    assign o_ok_lightness = lab[0];
    assign o_ok_a         = lab[1];
    assign o_ok_b         = lab[2];

endmodule

/* hw/rtl/xyzok_checker.sv */
// Port-level checks for the converter top level, bound onto every instance.
// Depends on xyzok_pkg and xyz_to_oklab_converter_unit.
module xyzok_checker import xyzok_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   o_busy,
    input logic signed [InW-1:0]  i_x_value,
    input logic signed [InW-1:0]  i_y_value,
    input logic signed [InW-1:0]  i_z_value,
    input logic                   i_line_end,
    input logic                   o_valid,
    input logic signed [OutW-1:0] o_ok_lightness,
    input logic signed [OutW-1:0] o_ok_a,
    input logic signed [OutW-1:0] o_ok_b,
    input logic                   o_line_end_out
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised on a pipeline without stalls");

    a_result_has_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, Latency))
        else $error("result without a transfer at the pipeline latency");

    a_line_end_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_end_out == $past(i_line_end, Latency)))
        else $error("line end flag does not match its pixel");

    a_zero_in_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_x_value == '0 && i_y_value == '0 && i_z_value == '0, Latency)
        |-> (o_ok_lightness == '0 && o_ok_a == '0 && o_ok_b == '0))
        else $error("black pixel does not map to zero");
endmodule

bind xyz_to_oklab_converter_unit xyzok_checker u_xyzok_checker (.*);
